@@ rtl/dps_pkg.sv @@
// ----------------------------------------------------------------------------
// Debounced pulse statistics package
// Shared types and constants for the per-channel pulse record logic.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int unsigned NumChannels = 2;
  localparam int unsigned ChIdxW      = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  localparam int unsigned SecW   = 32;
  localparam int unsigned TickW  = 10;
  localparam int unsigned CountW = 16;
  localparam int unsigned IntvW  = 16;

  localparam logic [SecW-1:0]   LongGapMask   = 32'hFFFF_FFC0;
  localparam logic [IntvW-1:0]  IntervalMax   = 16'hFFFF;
  localparam logic [CountW-1:0] CountMax      = 16'hFFFF;
  localparam logic [IntvW-1:0]  DebounceReset = 16'd128;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 120;

  typedef enum logic {
    OP_PULSE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            channel;
    logic [SecW-1:0] epoch_seconds;
    logic [TickW-1:0] subsecond_ticks;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SecW-1:0]   first_seconds;
    logic [TickW-1:0]  first_ticks;
    logic [SecW-1:0]   last_seconds;
    logic [TickW-1:0]  last_ticks;
    logic [IntvW-1:0]  min_interval;
  } rec_t;

  typedef struct packed {
    logic accepted;
    logic has_data;
    rec_t rec;
  } result_t;

  typedef struct packed {
    logic rec_wr;
    logic pending_wr;
    logic pending;
  } upd_ctrl_t;

endpackage

@@ rtl/dps_update.sv @@
// ----------------------------------------------------------------------------
// Pulse record update
// Works out the interval, the debounce decision and the new channel record.
// ----------------------------------------------------------------------------
module dps_update import dps_pkg::*; (
  input  item_t            item_i,
  input  logic             ch_ok_i,
  input  rec_t             rec_i,
  input  logic             pending_i,
  input  logic [IntvW-1:0] debounce_i,
  output rec_t             rec_o,
  output upd_ctrl_t        ctrl_o,
  output result_t          result_o
);

  logic [SecW-1:0]  dsec;
  logic [IntvW-1:0] interval;
  logic             pass;

  always_comb begin
    dsec = item_i.epoch_seconds - rec_i.last_seconds;
    if ((dsec & LongGapMask) == '0) begin
      interval = {dsec[IntvW-TickW-1:0], {TickW{1'b0}}}
               + IntvW'(item_i.subsecond_ticks) - IntvW'(rec_i.last_ticks);
    end else begin
      interval = IntervalMax;
    end
    pass = (interval >= debounce_i);
  end

  always_comb begin
    rec_o             = rec_i;
    ctrl_o            = '0;
    result_o          = '0;
    if (ch_ok_i) begin
      result_o.has_data = pending_i;
      unique case (item_i.op)
        OP_READ: begin
          ctrl_o.pending_wr = 1'b1;
          ctrl_o.pending    = 1'b0;
        end
        OP_PULSE: begin
          if (pass) begin
            ctrl_o.rec_wr       = 1'b1;
            ctrl_o.pending_wr   = 1'b1;
            ctrl_o.pending      = 1'b1;
            rec_o.last_seconds  = item_i.epoch_seconds;
            rec_o.last_ticks    = item_i.subsecond_ticks;
            if (!pending_i) begin
              rec_o.count         = CountW'(1);
              rec_o.first_seconds = item_i.epoch_seconds;
              rec_o.first_ticks   = item_i.subsecond_ticks;
              rec_o.min_interval  = interval;
            end else begin
              if (interval < rec_i.min_interval) begin
                rec_o.min_interval = interval;
              end
              if (rec_i.count != CountMax) begin
                rec_o.count = rec_i.count + CountW'(1);
              end
            end
          end
        end
        default: begin
          ctrl_o.pending_wr = 1'b0;
        end
      endcase
      result_o.accepted = (item_i.op == OP_PULSE) && pass;
      result_o.rec      = rec_o;
    end
  end

endmodule

@@ rtl/debounced_pulse_statistics.sv @@
// ----------------------------------------------------------------------------
// Debounced pulse statistics
// Per-channel pulse counter with debounce, first and last timestamps and the
// smallest interval seen; a read returns the record and clears its flag.
// Each item waits in the input register, its result in the output register.
// Throughput: one item per cycle while the output is not stalled.
// Reset: all records and flags clear, the debounce threshold becomes 128.
// ----------------------------------------------------------------------------
module debounced_pulse_statistics import dps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IntvW-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // seconds [31:0], ticks [41:32], zero fill [47:42]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // op [0], channel [1]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // count [15:0], first seconds [47:16], first ticks [57:48],
  // last seconds [89:58], last ticks [99:90], minimum interval [115:100],
  // zero fill [119:116]
  output logic [OutDataW-1:0] m_axis_tdata,
  // accepted [0], has data [1]
  output logic [1:0]          m_axis_tuser
);

  logic [IntvW-1:0]  debounce_q;
  logic              in_vld_q;
  item_t             item_q;
  logic              out_vld_q;
  result_t           res_q;
  rec_t              rec_q     [NumChannels];
  logic              pending_q [NumChannels];

  logic              adv;
  logic              ch_ok;
  logic [ChIdxW-1:0] ch_idx;
  rec_t              rec_d;
  upd_ctrl_t         ctrl;
  result_t           res_d;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign ch_ok         = (int'(item_q.channel) < NumChannels);
  assign ch_idx        = ChIdxW'(item_q.channel);

  dps_update u_update (
    .item_i    (item_q),
    .ch_ok_i   (ch_ok),
    .rec_i     (rec_q[ch_idx]),
    .pending_i (pending_q[ch_idx]),
    .debounce_i(debounce_q),
    .rec_o     (rec_d),
    .ctrl_o    (ctrl),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.op              <= op_e'(s_axis_tuser[0]);
      item_q.channel         <= s_axis_tuser[1];
      item_q.epoch_seconds   <= s_axis_tdata[SecW-1:0];
      item_q.subsecond_ticks <= s_axis_tdata[SecW+TickW-1:SecW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        rec_q[i]     <= '0;
        pending_q[i] <= 1'b0;
      end
    end else if (adv) begin
      if (ctrl.rec_wr) begin
        rec_q[ch_idx] <= rec_d;
      end
      if (ctrl.pending_wr) begin
        pending_q[ch_idx] <= ctrl.pending;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = {res_q.has_data, res_q.accepted};
  assign m_axis_tdata  = {4'b0000,
                          res_q.rec.min_interval,
                          res_q.rec.last_ticks,
                          res_q.rec.last_seconds,
                          res_q.rec.first_ticks,
                          res_q.rec.first_seconds,
                          res_q.rec.count};

  // An accepted pulse leaves unread data on its channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && ctrl.rec_wr |=> pending_q[$past(ch_idx)])
    else $error("accepted pulse did not set the data flag");

  // A counted pulse is never reported with an empty count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[CountW-1:0] != '0)
    else $error("accepted pulse reported with zero count");

  // A stalled item stays in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(item_q))
    else $error("stalled item lost from the input register");

  // A read never touches the record itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && item_q.op == OP_READ |-> !ctrl.rec_wr)
    else $error("read transfer modified the record");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Debounced pulse statistics testbench
// Sends pulse and read items on both channels and compares every result with
// a local model of the per-channel records or with the value that the
// directed table expects. A short table of directed items comes first, then
// random phases under several debounce thresholds, and a short run with a
// zero threshold. The sender works in bursts or, in some phases, steadily;
// the receiver stalls on patterns of its own.
module tb_top;
  import dps_pkg::*;

  localparam int unsigned IdleLimit = 2000;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [IntvW-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  rec_t             chan_rec [NumChannels];
  bit               chan_pending [NumChannels];
  logic [IntvW-1:0] debounce_thr = DebounceReset;

  result_t  expected_records [$];
  dir_row_t directed_table [$];

  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  bit          steady_feed = 1'b0;

  int unsigned ready_mode = 0;
  int unsigned ready_left = 0;
  int unsigned ready_tick = 0;

  debounced_pulse_statistics dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  function automatic result_t make_res(input logic acc, input logic has,
                                       input logic [CountW-1:0] cnt,
                                       input logic [SecW-1:0] fs, input logic [TickW-1:0] ft,
                                       input logic [SecW-1:0] ls, input logic [TickW-1:0] lt,
                                       input logic [IntvW-1:0] mi);
    result_t r;
    r.accepted               = acc;
    r.has_data               = has;
    r.rec.count              = cnt;
    r.rec.first_seconds      = fs;
    r.rec.first_ticks        = ft;
    r.rec.last_seconds       = ls;
    r.rec.last_ticks         = lt;
    r.rec.min_interval       = mi;
    return r;
  endfunction

  // Applies one item to the channel records and returns the result it gives.
  function automatic result_t advance_records(input item_t it);
    result_t          r;
    int unsigned      ch;
    logic [SecW-1:0]  dsec;
    logic [31:0]      span;
    logic [IntvW-1:0] gap;
    ch         = 32'(it.channel);
    r          = '0;
    r.has_data = chan_pending[ch];
    if (it.op == OP_READ) begin
      chan_pending[ch] = 1'b0;
    end else begin
      dsec = it.epoch_seconds - chan_rec[ch].last_seconds;
      gap  = IntervalMax;
      if ((dsec & LongGapMask) == '0) begin
        span = (dsec << TickW) + 32'(it.subsecond_ticks) - 32'(chan_rec[ch].last_ticks);
        gap  = span[IntvW-1:0];
      end
      if (gap >= debounce_thr) begin
        r.accepted                = 1'b1;
        chan_rec[ch].last_seconds = it.epoch_seconds;
        chan_rec[ch].last_ticks   = it.subsecond_ticks;
        if (!chan_pending[ch]) begin
          chan_pending[ch]           = 1'b1;
          chan_rec[ch].count         = CountW'(1);
          chan_rec[ch].first_seconds = it.epoch_seconds;
          chan_rec[ch].first_ticks   = it.subsecond_ticks;
          chan_rec[ch].min_interval  = gap;
        end else begin
          if (gap < chan_rec[ch].min_interval) begin
            chan_rec[ch].min_interval = gap;
          end
          if (chan_rec[ch].count != CountMax) begin
            chan_rec[ch].count = chan_rec[ch].count + 1'b1;
          end
        end
      end
    end
    r.rec = chan_rec[ch];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic dir_row(input op_e op, input logic ch, input logic [SecW-1:0] s,
                         input logic [TickW-1:0] t, input bit typed, input result_t want);
    dir_row_t row;
    row.it.op              = op;
    row.it.channel         = ch;
    row.it.epoch_seconds   = s;
    row.it.subsecond_ticks = t;
    row.typed              = typed;
    row.want               = want;
    directed_table.push_back(row);
  endtask

  // Called just after a rising edge; returns just after the edge of the transfer.
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    result_t predicted;
    if (!steady_feed && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, it.subsecond_ticks, it.epoch_seconds};
    s_axis_tuser  <= {it.channel, it.op};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_records(it);
    expected_records.push_back(typed ? want : predicted);
  endtask

  task automatic set_debounce(input logic [IntvW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    debounce_thr = value;
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(32, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    ready_tick <= ready_tick + 1;
    case (ready_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= (ready_tick[1:0] == 2'd0);
      end
    endcase
  end

  always @(posedge clk_i) begin : result_monitor
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted          = m_axis_tuser[0];
      got.has_data          = m_axis_tuser[1];
      got.rec.count         = m_axis_tdata[15:0];
      got.rec.first_seconds = m_axis_tdata[47:16];
      got.rec.first_ticks   = m_axis_tdata[57:48];
      got.rec.last_seconds  = m_axis_tdata[89:58];
      got.rec.last_ticks    = m_axis_tdata[99:90];
      got.rec.min_interval  = m_axis_tdata[115:100];
      if (expected_records.size() == 0) begin
        report_mismatch("result transfer with no result expected");
      end else begin
        want = expected_records.pop_front();
        check_field("accepted", 32'(got.accepted), 32'(want.accepted));
        check_field("has_data", 32'(got.has_data), 32'(want.has_data));
        check_field("count", 32'(got.rec.count), 32'(want.rec.count));
        check_field("first_seconds", got.rec.first_seconds, want.rec.first_seconds);
        check_field("first_ticks", 32'(got.rec.first_ticks), 32'(want.rec.first_ticks));
        check_field("last_seconds", got.rec.last_seconds, want.rec.last_seconds);
        check_field("last_ticks", 32'(got.rec.last_ticks), 32'(want.rec.last_ticks));
        check_field("min_interval", 32'(got.rec.min_interval), 32'(want.rec.min_interval));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    item_t            it;
    int unsigned      ch;
    int unsigned      kind;
    logic [41:0]      stamp;
    logic [41:0]      step;
    logic [IntvW-1:0] thr_list [$];

    for (int i = 0; i < NumChannels; i++) begin
      chan_rec[i]     = '0;
      chan_pending[i] = 1'b0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_row(OP_READ,  1'b0, 32'd0, 10'd0, 1'b1, '0);
    dir_row(OP_READ,  1'b1, 32'hFFFF_FFFF, 10'h3FF, 1'b1, '0);
    dir_row(OP_PULSE, 1'b0, 32'd0, 10'd0, 1'b1, '0);
    dir_row(OP_PULSE, 1'b0, 32'd0, 10'd127, 1'b1, '0);
    dir_row(OP_PULSE, 1'b0, 32'd0, 10'd128, 1'b1,
            make_res(1'b1, 1'b0, 16'd1, 32'd0, 10'd128, 32'd0, 10'd128, 16'd128));
    dir_row(OP_PULSE, 1'b0, 32'd1, 10'd0, 1'b0, '0);
    dir_row(OP_PULSE, 1'b0, 32'd1, 10'd1023, 1'b0, '0);
    dir_row(OP_READ,  1'b0, 32'd0, 10'd0, 1'b0, '0);
    dir_row(OP_READ,  1'b0, 32'd0, 10'd0, 1'b0, '0);
    dir_row(OP_PULSE, 1'b1, 32'hFFFF_FFFF, 10'd1023, 1'b1,
            make_res(1'b1, 1'b0, 16'd1, 32'hFFFF_FFFF, 10'd1023, 32'hFFFF_FFFF, 10'd1023,
                     16'hFFFF));
    dir_row(OP_PULSE, 1'b1, 32'd0, 10'd0, 1'b0, '0);
    dir_row(OP_PULSE, 1'b1, 32'h3F, 10'd1023, 1'b0, '0);
    dir_row(OP_PULSE, 1'b1, 32'h7E, 10'd0, 1'b0, '0);
    dir_row(OP_PULSE, 1'b1, 32'h7E, 10'd0, 1'b0, '0);
    dir_row(OP_PULSE, 1'b1, 32'hBD, 10'd1023, 1'b0, '0);
    dir_row(OP_PULSE, 1'b1, 32'hBD, 10'd0, 1'b0, '0);
    dir_row(OP_READ,  1'b1, 32'd0, 10'd0, 1'b0, '0);
    dir_row(OP_PULSE, 1'b0, 32'hAAAA_AAAA, 10'h155, 1'b0, '0);
    dir_row(OP_PULSE, 1'b0, 32'h5555_5555, 10'h2AA, 1'b0, '0);
    dir_row(OP_READ,  1'b0, 32'd0, 10'd0, 1'b0, '0);

    foreach (directed_table[i]) begin
      send_item(directed_table[i].it, directed_table[i].typed, directed_table[i].want);
    end

    thr_list.push_back(16'd0);
    thr_list.push_back(16'd1);
    thr_list.push_back(16'hFFFF);
    thr_list.push_back(16'd1024);
    thr_list.push_back(16'($urandom));
    thr_list.push_back(16'($urandom_range(2, 400)));
    thr_list.push_back(DebounceReset);

    foreach (thr_list[p]) begin
      set_debounce(thr_list[p]);
      steady_feed = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 90; n++) begin
        kind                 = $urandom_range(0, 99);
        ch                   = $urandom_range(0, 1);
        it.op                = (kind < 15) ? OP_READ : OP_PULSE;
        it.channel           = ch[0];
        it.epoch_seconds     = $urandom;
        it.subsecond_ticks   = TickW'($urandom_range(0, 1023));
        if (kind >= 30) begin
          case ($urandom_range(0, 5))
            0: step = 42'($urandom_range(0, 3));
            1: step = 42'(debounce_thr) + 42'($urandom_range(0, 4)) - 42'd2;
            2: step = 42'($urandom_range(0, 65535));
            3: step = 42'($urandom_range(63 * 1024, 66 * 1024));
            4: step = 42'd0 - 42'($urandom_range(1, 1023));
            default: step = 42'({$urandom, $urandom});
          endcase
          stamp              = {chan_rec[ch].last_seconds, chan_rec[ch].last_ticks} + step;
          it.epoch_seconds   = stamp[41:10];
          it.subsecond_ticks = stamp[9:0];
        end
        send_item(it, 1'b0, '0);
      end
    end

    // A threshold of zero accepts every pulse, so the counts grow on each item.
    set_debounce(16'd0);
    steady_feed = 1'b1;
    for (int n = 0; n < 50; n++) begin
      it.op              = OP_PULSE;
      it.channel         = ($urandom_range(0, 15) == 0);
      it.epoch_seconds   = $urandom;
      it.subsecond_ticks = TickW'($urandom_range(0, 1023));
      send_item(it, 1'b0, '0);
    end
    it.op      = OP_READ;
    it.channel = 1'b0;
    send_item(it, 1'b0, '0);
    it.channel = 1'b1;
    send_item(it, 1'b0, '0);

    s_axis_tvalid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/dps_pkg.sv
rtl/dps_update.sv
rtl/debounced_pulse_statistics.sv
test/tb_top.sv
